// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/arbc_pkg.sv -----
// ---------------------------------------------------------------------------
// arbc_pkg
// Shared types and constants of the attribute raster border composer.
// ---------------------------------------------------------------------------
package arbc_pkg;

  localparam int SCREEN_LINES_DEF = 192;
  localparam int SCREEN_SLOTS_DEF = 32;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam int LINE_W = 9;
  localparam int SLOT_W = 6;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SLOTS_PER_LINE = 2'd0,
    CFG_SIDE_BORDER    = 2'd1,
    CFG_TOP_BORDER     = 2'd2,
    CFG_FLASH_PHASE    = 2'd3
  } cfg_reg_t;

  // One visible slot handed from the tracker to the shader.
  typedef struct packed {
    logic              screen;
    logic              invert;
    logic [2:0]        border;
    logic [7:0]        pix;
    logic [7:0]        attr;
    logic [LINE_W-1:0] line;
    logic [SLOT_W-1:0] col;
    logic              last;
  } stage_t;

endpackage

// ----- src/arbc_tracker.sv -----
// ---------------------------------------------------------------------------
// arbc_tracker
// Beam position, border colour and geometry registers; classifies each slot.
// ---------------------------------------------------------------------------
module arbc_tracker #(
  parameter int SCREEN_LINES = arbc_pkg::SCREEN_LINES_DEF,
  parameter int SCREEN_SLOTS = arbc_pkg::SCREEN_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [arbc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [arbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_fire,
  input  logic                            frame_start,
  input  logic [arbc_pkg::IN_DATA_W-1:0]  in_data,
  input  logic                            take,
  output logic                            ready,
  output logic                            st_valid,
  output arbc_pkg::stage_t                st
);
  import arbc_pkg::*;

  logic [6:0]        spl_r;
  logic [3:0]        side_r;
  logic [5:0]        top_r;
  logic              flash_r;
  logic [2:0]        border_r, border_nxt;
  logic [LINE_W-1:0] line_r, line_nxt, line_c;
  logic [SLOT_W-1:0] slot_r, slot_nxt, slot_c;
  logic              active_r, active_nxt, active_c;
  logic              st_valid_r;
  stage_t            st_r, st_nxt;

  logic       wr;
  logic [6:0] len;
  logic [7:0] vis_w, span, last_slot, slot8;
  logic [9:0] vis_h, line10;
  logic       emit, scr_line, scr_col, last;

  always_comb begin
    wr       = in_data[0] & ~in_data[1];
    active_c = frame_start | active_r;
    line_c   = frame_start ? '0 : line_r;
    slot_c   = frame_start ? '0 : slot_r;
    slot8    = {2'b0, slot_c};
    line10   = {1'b0, line_c};

    if (spl_r == 7'd0)       len = 7'd1;
    else if (spl_r > 7'd64)  len = 7'd64;
    else                     len = spl_r;

    vis_w     = 8'(SCREEN_SLOTS) + {3'b0, side_r, 1'b0};
    vis_h     = 10'(SCREEN_LINES) + {3'b0, top_r, 1'b0};
    span      = (vis_w < {1'b0, len}) ? vis_w : {1'b0, len};
    last_slot = span - 8'd1;

    emit     = active_c && (slot8 <= last_slot);
    scr_line = (line10 >= {4'b0, top_r}) && (line10 < {4'b0, top_r} + 10'(SCREEN_LINES));
    scr_col  = (slot8 >= {4'b0, side_r}) && (slot8 < {4'b0, side_r} + 8'(SCREEN_SLOTS));
    last     = emit && (line10 == vis_h - 10'd1) && (slot8 == last_slot);

    border_nxt = wr ? in_data[4:2] : border_r;

    active_nxt = active_c;
    line_nxt   = line_c;
    slot_nxt   = slot_c;
    if (last) begin
      active_nxt = 1'b0;
      line_nxt   = '0;
      slot_nxt   = '0;
    end else if (active_c) begin
      if ({1'b0, slot_c} + 7'd1 >= len) begin
        slot_nxt = '0;
        line_nxt = line_c + 9'd1;
      end else begin
        slot_nxt = slot_c + 6'd1;
      end
    end

    st_nxt.screen = scr_line & scr_col;
    st_nxt.invert = in_data[25] & flash_r;
    st_nxt.border = border_nxt;
    st_nxt.pix    = in_data[17:10];
    st_nxt.attr   = in_data[25:18];
    st_nxt.line   = line_c;
    st_nxt.col    = slot_c;
    st_nxt.last   = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spl_r      <= 7'd56;
      side_r     <= 4'd4;
      top_r      <= 6'd24;
      flash_r    <= 1'b0;
      border_r   <= '0;
      line_r     <= '0;
      slot_r     <= '0;
      active_r   <= 1'b0;
      st_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          CFG_SLOTS_PER_LINE: spl_r   <= cfg_wdata;
          CFG_SIDE_BORDER:    side_r  <= cfg_wdata[3:0];
          CFG_TOP_BORDER:     top_r   <= cfg_wdata[5:0];
          CFG_FLASH_PHASE:    flash_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        border_r   <= border_nxt;
        line_r     <= line_nxt;
        slot_r     <= slot_nxt;
        active_r   <= active_nxt;
        st_valid_r <= emit;
      end else if (take) begin
        st_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  assign ready    = ~st_valid_r | take;
  assign st_valid = st_valid_r;
  assign st       = st_r;

endmodule

// ----- src/arbc_shade.sv -----
// ---------------------------------------------------------------------------
// arbc_shade
// Attribute decode to eight colour indices; output register of the block.
// ---------------------------------------------------------------------------
module arbc_shade (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            st_valid,
  input  arbc_pkg::stage_t                st,
  output logic                            take,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [arbc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import arbc_pkg::*;

  logic                  valid_r;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic                  last_r;
  logic [3:0]            pen, paper;
  logic [7:0]            bits;
  logic [31:0]           colors;
  logic                  adv;

  always_comb begin
    pen   = {st.attr[6], st.attr[2:0]};
    paper = st.attr[6:3];
    bits  = st.pix ^ {8{st.invert}};
    for (int i = 0; i < 8; i++) begin
      colors[31-4*i -: 4] = bits[7-i] ? pen : paper;
    end
    if (!st.screen) colors = {8{1'b0, st.border}};
    data_nxt = {1'b0, st.col, st.line, colors};
  end

  assign adv  = ~valid_r | out_tready;
  assign take = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && st_valid) begin
      data_r <= data_nxt;
      last_r <= st.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

// ----- src/attribute_raster_border_composer.sv -----
// ---------------------------------------------------------------------------
// attribute_raster_border_composer
// Beam slot to eight-pixel colour word composer with border and flash.
// ---------------------------------------------------------------------------
//  channel  dir  handshake              content
//  in_      in   in_tvalid/in_tready    one beam slot, frame start in tuser
//  out_     out  out_tvalid/out_tready  eight colour indices, line, column
//  cfg_     in   cfg_we                 geometry and flash phase registers
//
//  One word per clock while out_tready stays high. A taken slot loads the
//  tracker register, then the shader output register once that is free;
//  that register drives out_tvalid. Flyback and idle slots produce no output word.
//  Reset (synchronous, active low) clears position, border colour and
//  loads the default geometry. With the output stalled, slots that give no
//  word are still taken until a visible slot fills the tracker register;
//  then in_tready drops until the output register frees up.
// ---------------------------------------------------------------------------
module attribute_raster_border_composer #(
  parameter int SCREEN_LINES = arbc_pkg::SCREEN_LINES_DEF,
  parameter int SCREEN_SLOTS = arbc_pkg::SCREEN_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_valid, out_addr_lsb, out_data[7:0], pixel_byte[7:0], attr_byte[7:0]
  input  logic [arbc_pkg::IN_DATA_W-1:0]  in_tdata,
  // frame_start
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pixel_colors[31:0], line[8:0], column_slot[5:0]
  output logic [arbc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [arbc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [arbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import arbc_pkg::*;

  logic   in_fire, take, st_valid;
  stage_t st;

  assign in_fire = in_tvalid & in_tready;

  arbc_tracker #(
    .SCREEN_LINES(SCREEN_LINES),
    .SCREEN_SLOTS(SCREEN_SLOTS)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_fire    (in_fire),
    .frame_start(in_tuser),
    .in_data    (in_tdata),
    .take       (take),
    .ready      (in_tready),
    .st_valid   (st_valid),
    .st         (st)
  );

  arbc_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_valid  (st_valid),
    .st        (st),
    .take      (take),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

// ----- src/arbc_checker.sv -----
// ---------------------------------------------------------------------------
// arbc_checker
// Port-level checks of the composer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module arbc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [arbc_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [arbc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            cfg_we,
  input logic [arbc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input logic [arbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic out_stall;

  assign out_stall = out_tvalid & ~out_tready;

  `ASSERT_NXT_ALWAYS(a_rst_idle, clk, !rst_n, !out_tvalid, "output valid after reset")
  `ASSERT_NXT_ALWAYS(a_rst_ready, clk, !rst_n, in_tready, "input blocked after reset")
  `ASSERT_NXT(a_stall_hold, clk, rst_n, out_stall, out_tvalid && $stable({out_tlast, out_tdata}), "stalled word changed")
  `ASSERT_IMP(a_empty_ready, clk, rst_n, !out_tvalid, in_tready, "input blocked with empty output")

endmodule

bind attribute_raster_border_composer arbc_checker u_arbc_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Raster border composer testbench
// Streams beam slots into the composer under several frame geometries and
// flash settings, predicts every colour word in a local model of the beam
// tracker and cell shader, and checks each output word in order. Sender and
// receiver idle at random; one phase holds the output off long enough to
// back the input up.
// ----------------------------------------------------------------------------
module testbench;
  import arbc_pkg::*;

  localparam int N_LINES   = SCREEN_LINES_DEF;
  localparam int N_SLOTS   = SCREEN_SLOTS_DEF;
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN_MAX = 20000;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic       frame_start;
    logic       port_wr;
    logic       port_odd;
    logic [7:0] port_data;
    logic [7:0] bitmap;
    logic [7:0] attr;
  } beam_slot_t;

  typedef struct packed {
    logic [31:0]       colors;
    logic [LINE_W-1:0] line;
    logic [SLOT_W-1:0] col;
    logic              last;
  } color_word_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow configuration and beam state
  logic [6:0] shadow_spl;
  logic [3:0] shadow_side;
  logic [5:0] shadow_top;
  logic       shadow_flash;
  logic [2:0] beam_border;
  int         beam_line;
  int         beam_slot;
  bit         beam_in_frame;

  color_word_t pending_words[$];

  int send_idle_pct;
  int rx_stall_pct;
  int hold_serial;
  int error_count;
  int slots_sent;
  int words_checked;
  int frames_done;

  attribute_raster_border_composer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic compose_slot(input beam_slot_t s);
    int          len;
    int          vis_w;
    int          vis_h;
    int          last_slot;
    int          i;
    bit          in_screen;
    logic [7:0]  bits;
    logic [3:0]  pen;
    logic [3:0]  paper;
    color_word_t w;
    len = (shadow_spl == 0) ? 1 : ((shadow_spl > 64) ? 64 : int'(shadow_spl));
    vis_w = N_SLOTS + 2 * shadow_side;
    vis_h = N_LINES + 2 * shadow_top;
    last_slot = ((vis_w < len) ? vis_w : len) - 1;
    if (s.frame_start) begin
      beam_in_frame = 1'b1;
      beam_line = 0;
      beam_slot = 0;
    end
    if (s.port_wr && !s.port_odd)
      beam_border = s.port_data[2:0];
    if (!beam_in_frame)
      return;
    if (beam_slot <= last_slot) begin
      in_screen = beam_line >= shadow_top && beam_line < shadow_top + N_LINES &&
                  beam_slot >= shadow_side && beam_slot < shadow_side + N_SLOTS;
      if (in_screen) begin
        bits = s.bitmap ^ {8{s.attr[7] & shadow_flash}};
        pen = {s.attr[6], s.attr[2:0]};
        paper = s.attr[6:3];
        for (i = 0; i < 8; i++)
          w.colors[4*i +: 4] = bits[i] ? pen : paper;
      end else begin
        w.colors = {8{1'b0, beam_border}};
      end
      w.line = beam_line[LINE_W-1:0];
      w.col = beam_slot[SLOT_W-1:0];
      w.last = (beam_line == vis_h - 1) && (beam_slot == last_slot);
      pending_words.push_back(w);
      if (w.last) begin
        beam_in_frame = 1'b0;
        beam_line = 0;
        beam_slot = 0;
        return;
      end
    end
    if (beam_slot + 1 >= len) begin
      beam_slot = 0;
      beam_line = (beam_line + 1) & 511;
    end else begin
      beam_slot = (beam_slot + 1) & 63;
    end
  endtask

  task automatic drive_slot(input beam_slot_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, s.attr, s.bitmap, s.port_data, s.port_odd, s.port_wr};
    in_tuser <= s.frame_start;
    do @(posedge clk); while (!in_tready);
    compose_slot(s);
    slots_sent++;
  endtask

  function automatic beam_slot_t mk_slot(input bit fs, input bit wr, input bit odd,
                                         input logic [7:0] data, input logic [7:0] pix,
                                         input logic [7:0] attr);
    beam_slot_t s;
    s.frame_start = fs;
    s.port_wr = wr;
    s.port_odd = odd;
    s.port_data = data;
    s.bitmap = pix;
    s.attr = attr;
    return s;
  endfunction

  task automatic drain;
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (pending_words.size() != 0) begin
      $display("%0d colour words never arrived", pending_words.size());
      error_count += pending_words.size();
      pending_words.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input int spl, input int side, input int top, input int flash);
    shadow_spl = spl[6:0];
    shadow_side = side[3:0];
    shadow_top = top[5:0];
    shadow_flash = flash[0];
    cfg_we <= 1'b1;
    cfg_addr <= CFG_SLOTS_PER_LINE;
    cfg_wdata <= spl[6:0];
    @(posedge clk);
    cfg_addr <= CFG_SIDE_BORDER;
    cfg_wdata <= {3'b0, side[3:0]};
    @(posedge clk);
    cfg_addr <= CFG_TOP_BORDER;
    cfg_wdata <= {1'b0, top[5:0]};
    @(posedge clk);
    cfg_addr <= CFG_FLASH_PHASE;
    cfg_wdata <= {6'b0, flash[0]};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int rx_pct);
    send_idle_pct = send_pct;
    rx_stall_pct = rx_pct;
  endtask

  // well-formed frames with random content, occasional restarts mid-frame
  task automatic run_stream(input int n_slots);
    beam_slot_t s;
    int         taken;
    taken = 0;
    while (taken < n_slots) begin
      s.frame_start = beam_in_frame ? ($urandom_range(199) == 0) : ($urandom_range(4) != 0);
      s.port_wr = ($urandom_range(5) == 0);
      s.port_odd = $urandom_range(1);
      s.port_data = $urandom_range(255);
      s.bitmap = $urandom_range(255);
      s.attr = $urandom_range(255);
      if (s.frame_start || beam_in_frame)
        taken++;
      drive_slot(s);
    end
  endtask

  task automatic test_directed;
    set_idling(0, 0);
    // idle block: border writes still land, odd port ignored
    drive_slot(mk_slot(0, 0, 0, 8'h00, 8'hff, 8'hff));
    drive_slot(mk_slot(0, 1, 0, 8'hff, 8'h00, 8'h00));
    drive_slot(mk_slot(0, 1, 1, 8'h03, 8'h00, 8'h00));
    drive_slot(mk_slot(1, 0, 0, 8'h00, 8'hff, 8'hff));
    drive_slot(mk_slot(0, 1, 0, 8'h02, 8'h00, 8'h00));
    drive_slot(mk_slot(0, 1, 1, 8'h05, 8'h00, 8'h00));
    drain();
    configure(40, 0, 0, 0);
    drive_slot(mk_slot(1, 0, 0, 8'h00, 8'h00, 8'h00));
    drive_slot(mk_slot(0, 0, 0, 8'h00, 8'hff, 8'hff));
    drive_slot(mk_slot(0, 1, 0, 8'h04, 8'h5a, 8'h47));
    drive_slot(mk_slot(0, 0, 0, 8'h00, 8'h81, 8'hb8));
    drain();
    configure(40, 0, 0, 1);
    drive_slot(mk_slot(0, 0, 0, 8'h00, 8'h0f, 8'h80));
    drive_slot(mk_slot(0, 0, 0, 8'h00, 8'hf0, 8'h7f));
    drive_slot(mk_slot(1, 0, 0, 8'h00, 8'hff, 8'hc7));
    drive_slot(mk_slot(0, 0, 0, 8'h00, 8'h3c, 8'h38));
    drain();
    // line length clamps at both ends
    configure(0, 0, 0, 1);
    drive_slot(mk_slot(1, 0, 0, 8'h00, 8'ha5, 8'h96));
    drive_slot(mk_slot(0, 0, 0, 8'h00, 8'h5a, 8'h69));
    drive_slot(mk_slot(0, 1, 0, 8'h01, 8'h00, 8'h00));
    drain();
    configure(100, 8, 48, 0);
    drive_slot(mk_slot(1, 1, 0, 8'h06, 8'h00, 8'h00));
    drive_slot(mk_slot(0, 0, 0, 8'h00, 8'hff, 8'hff));
    drive_slot(mk_slot(0, 1, 1, 8'h01, 8'h00, 8'h00));
    drain();
  endtask

  task automatic test_thin_frames;
    drain();
    configure(1, 0, 0, 0);
    set_idling(0, 0);
    run_stream(400);
  endtask

  task automatic test_tall_border;
    drain();
    configure(0, 8, 48, 1);
    set_idling(86, 0);
    run_stream(300);
  endtask

  task automatic test_wide_lines;
    drain();
    configure(64, 8, 0, 0);
    set_idling(0, 86);
    run_stream(200);
  endtask

  task automatic test_short_lines;
    drain();
    configure(40, 8, 48, 1);
    set_idling(0, 0);
    run_stream(100);
  endtask

  task automatic test_mixed;
    drain();
    configure(2, 3, 10, 1);
    set_idling(18, 18);
    run_stream(450);
  endtask

  task automatic test_backpressure;
    drain();
    configure(1, 0, 0, 1);
    set_idling(0, 0);
    hold_serial++;
    run_stream(250);
  endtask

  // receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    int hold_seen;
    int hold_left;
    if (hold_serial != hold_seen) begin
      hold_seen = hold_serial;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // output side: in-order check
  always @(posedge clk) begin
    color_word_t got;
    color_word_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.colors = out_tdata[31:0];
        got.line = out_tdata[40:32];
        got.col = out_tdata[46:41];
        got.last = out_tlast;
        if (pending_words.size() == 0) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display("unexpected word: colors=%h line=%0d col=%0d last=%b",
                     got.colors, got.line, got.col, got.last);
        end else begin
          want = pending_words.pop_front();
          words_checked++;
          if (want.last)
            frames_done++;
          if (got.colors !== want.colors || got.line !== want.line ||
              got.col !== want.col || got.last !== want.last) begin
            error_count++;
            if (error_count <= MAX_SHOWN)
              $display("mismatch: expected colors=%h line=%0d col=%0d last=%b, got colors=%h line=%0d col=%0d last=%b",
                       want.colors, want.line, want.col, want.last,
                       got.colors, got.line, got.col, got.last);
          end
        end
      end
    end
  end

  initial begin
    shadow_spl = 7'd56;
    shadow_side = 4'd4;
    shadow_top = 6'd24;
    shadow_flash = 1'b0;
    beam_border = 3'd0;
    beam_line = 0;
    beam_slot = 0;
    beam_in_frame = 1'b0;
    send_idle_pct = 0;
    rx_stall_pct = 0;
    hold_serial = 0;
    error_count = 0;
    slots_sent = 0;
    words_checked = 0;
    frames_done = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_thin_frames();
    test_tall_border();
    test_wide_lines();
    test_short_lines();
    test_mixed();
    test_backpressure();
    drain();
    $display("Sent %0d beam slots, checked %0d colour words, %0d frames ran to the end.",
             slots_sent, words_checked, frames_done);
    $display("Geometries from one-slot lines to full 64-slot lines, flash on and off.");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
